FILE: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, quiet while reset is asserted
`define I2CEE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("i2cee port check failed");

// concurrent check that also runs through reset
`define I2CEE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("i2cee reset check failed");

`endif

FILE: sv/i2cee_pkg.sv
// shared types and constants of the serial eeprom slave
`default_nettype none

package i2cee_pkg;

    // transfer phase, also reported on the phase code output
    typedef enum logic [2:0] {
        PH_STANDBY   = 3'd0,
        PH_WAIT_STOP = 3'd1,
        PH_WORD7     = 3'd2,
        PH_DEVICE    = 3'd3,
        PH_ADDR_HIGH = 3'd4,
        PH_ADDR_LOW  = 3'd5,
        PH_READ      = 3'd6,
        PH_WRITE     = 3'd7
    } t_phase;

    // configuration register indexes
    localparam logic [1:0] CFG_ADDR_MODE = 2'd0;
    localparam logic [1:0] CFG_SIZE_MASK = 2'd1;
    localparam logic [1:0] CFG_PAGE_MASK = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DEV_W       = 20;
    localparam int WADDR_W     = 16;

    // address mode codes
    localparam logic [4:0] AMB_X24C01   = 5'd7;
    localparam logic [4:0] AMB_TWO_BYTE = 5'd16;

    // register reset values
    localparam logic [4:0]  AMB_RESET       = 5'd7;
    localparam logic [15:0] SIZE_MASK_RESET = 16'h007f;
    localparam logic [7:0]  PAGE_MASK_RESET = 8'h03;

    // bit counter position of the acknowledge clock
    localparam logic [3:0] ACK_SLOT = 4'd9;

    // what the output stage needs to know about one stepped item
    typedef struct packed {
        t_phase     phase;
        logic [3:0] bit_count;
        logic       sda;
    } t_step_info;

endpackage

`default_nettype wire

FILE: sv/i2cee_mem.sv
// byte array with registered read, write forwarding and erase pass after reset
`default_nettype none

module i2cee_mem #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_we,
    input  wire logic [MEM_ADDR_BITS-1:0] i_waddr,
    input  wire logic [7:0]               i_wdata,
    input  wire logic                     i_re,
    input  wire logic [MEM_ADDR_BITS-1:0] i_raddr,
    output logic      [7:0]               o_rdata,
    output logic                          o_busy
);

    localparam int DEPTH = 1 << MEM_ADDR_BITS;

    logic [7:0]               r_mem [DEPTH];
    logic [7:0]               r_rdata;
    logic                     r_clr_busy;
    logic [MEM_ADDR_BITS-1:0] r_clr_addr;

    logic                     wr_en;
    logic [MEM_ADDR_BITS-1:0] wr_addr;
    logic [7:0]               wr_data;

    // erase pass owns the write port until every byte reads 0xff
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = 8'hff;
        end else begin
            wr_en   = i_we;
            wr_addr = i_waddr;
            wr_data = i_wdata;
        end
    end

    // erase sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // array write and read, a same-address write is forwarded to the read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_re) begin
            if (wr_en && (wr_addr == i_raddr)) begin
                r_rdata <= wr_data;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

`default_nettype wire

FILE: sv/i2cee_proto.sv
// bus protocol sequencer: start/stop detection, bit counting, address and data latching
`default_nettype none

module i2cee_proto #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [i2cee_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [i2cee_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                                i_step,
    input  wire logic                                i_sda,
    input  wire logic                                i_scl,
    output logic                                     o_we,
    output logic      [MEM_ADDR_BITS-1:0]            o_waddr,
    output logic      [7:0]                          o_wdata,
    output logic      [MEM_ADDR_BITS-1:0]            o_raddr,
    output i2cee_pkg::t_step_info                    o_info
);

    // configuration
    logic [4:0]  r_amb;
    logic [15:0] r_size_mask;
    logic [7:0]  r_page_mask;

    // protocol state
    i2cee_pkg::t_phase                r_phase, n_phase;
    logic [3:0]                       r_bc, n_bc;
    logic [i2cee_pkg::WADDR_W-1:0]    r_wa, n_wa;
    logic [i2cee_pkg::DEV_W-1:0]      r_dev, n_dev;
    logic                             r_rnw, n_rnw;
    logic [7:0]                       r_wbyte, n_wbyte;
    logic                             r_prev_scl, r_prev_sda;

    logic                             hold_high, start, stop, fall, rise;
    logic                             wr_fire;
    logic [4:0]                       pos;
    logic [15:0]                      page_mask_w;
    logic [i2cee_pkg::DEV_W-1:0]      cur_ab, nxt_ab;

    assign hold_high   = r_prev_scl & i_scl;
    assign start       = hold_high & r_prev_sda & ~i_sda;
    assign stop        = hold_high & ~r_prev_sda & i_sda;
    assign fall        = r_prev_scl & ~i_scl;
    assign rise        = ~r_prev_scl & i_scl;
    assign page_mask_w = {8'd0, r_page_mask};
    assign pos         = ((r_phase == i2cee_pkg::PH_ADDR_HIGH) ? 5'd16 : 5'd8) - {1'b0, r_bc};

    // next protocol state for one pin sample
    always_comb begin
        n_phase = r_phase;
        n_bc    = r_bc;
        n_wa    = r_wa;
        n_dev   = r_dev;
        n_rnw   = r_rnw;
        n_wbyte = r_wbyte;
        wr_fire = 1'b0;
        if (r_phase == i2cee_pkg::PH_WAIT_STOP) begin
            if (stop) begin
                n_phase = i2cee_pkg::PH_STANDBY;
            end
        end else if (start) begin
            n_bc = 4'd0;
            if (r_amb == i2cee_pkg::AMB_X24C01) begin
                n_wa    = '0;
                n_phase = i2cee_pkg::PH_WORD7;
            end else begin
                n_dev   = '0;
                n_phase = i2cee_pkg::PH_DEVICE;
            end
        end else if (r_phase != i2cee_pkg::PH_STANDBY) begin
            if (stop) begin
                n_phase = i2cee_pkg::PH_STANDBY;
            end else if (fall) begin
                // bit counter advances, the ack clock closes a byte
                if (r_bc < i2cee_pkg::ACK_SLOT) begin
                    n_bc = r_bc + 4'd1;
                end else begin
                    n_bc = 4'd1;
                    unique case (r_phase)
                        i2cee_pkg::PH_WORD7: begin
                            n_phase = r_rnw ? i2cee_pkg::PH_READ : i2cee_pkg::PH_WRITE;
                            n_wbyte = '0;
                        end
                        i2cee_pkg::PH_DEVICE: begin
                            n_dev = r_dev << r_amb;
                            if (r_rnw) begin
                                n_phase = i2cee_pkg::PH_READ;
                            end else begin
                                n_wa    = '0;
                                n_phase = (r_amb == i2cee_pkg::AMB_TWO_BYTE) ?
                                          i2cee_pkg::PH_ADDR_HIGH : i2cee_pkg::PH_ADDR_LOW;
                            end
                        end
                        i2cee_pkg::PH_ADDR_HIGH: begin
                            n_phase = i2cee_pkg::PH_ADDR_LOW;
                        end
                        i2cee_pkg::PH_ADDR_LOW: begin
                            n_phase = i2cee_pkg::PH_WRITE;
                            n_wbyte = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (rise) begin
                // data bits are latched on the rising clock
                unique case (r_phase)
                    i2cee_pkg::PH_WORD7: begin
                        if (r_bc < 4'd8) begin
                            n_wa = r_wa | (16'(i_sda) << (3'd7 - r_bc[2:0]));
                        end else if (r_bc == 4'd8) begin
                            n_rnw = i_sda;
                        end
                    end
                    i2cee_pkg::PH_DEVICE: begin
                        if (r_bc > 4'd4 && r_bc < 4'd8) begin
                            n_dev = r_dev | (20'(i_sda) << (3'd7 - r_bc[2:0]));
                        end else if (r_bc == 4'd8) begin
                            n_rnw = i_sda;
                        end
                    end
                    i2cee_pkg::PH_ADDR_HIGH, i2cee_pkg::PH_ADDR_LOW: begin
                        if (r_bc < i2cee_pkg::ACK_SLOT) begin
                            // address bits beyond the array size shift out device bits
                            if ({1'b0, r_size_mask} < (17'd1 << pos)) begin
                                n_dev = r_dev >> 1;
                            end else begin
                                n_wa = r_wa | (16'(i_sda) << pos);
                            end
                        end
                    end
                    i2cee_pkg::PH_READ: begin
                        if (r_bc == i2cee_pkg::ACK_SLOT) begin
                            if (i_sda) begin
                                n_phase = i2cee_pkg::PH_WAIT_STOP;
                            end else begin
                                n_wa = (r_wa + 16'd1) & r_size_mask;
                            end
                        end
                    end
                    i2cee_pkg::PH_WRITE: begin
                        if (r_bc < i2cee_pkg::ACK_SLOT) begin
                            n_wbyte = r_wbyte | (8'(i_sda) << (4'd8 - r_bc));
                        end else begin
                            wr_fire = 1'b1;
                            n_wbyte = '0;
                            n_wa    = (r_wa & ~page_mask_w) | ((r_wa + 16'd1) & page_mask_w);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amb       <= i2cee_pkg::AMB_RESET;
            r_size_mask <= i2cee_pkg::SIZE_MASK_RESET;
            r_page_mask <= i2cee_pkg::PAGE_MASK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                i2cee_pkg::CFG_ADDR_MODE: r_amb       <= i_cfg_data[4:0];
                i2cee_pkg::CFG_SIZE_MASK: r_size_mask <= i_cfg_data[15:0];
                i2cee_pkg::CFG_PAGE_MASK: r_page_mask <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // protocol state registers, advanced once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= i2cee_pkg::PH_STANDBY;
            r_bc       <= '0;
            r_wa       <= '0;
            r_dev      <= '0;
            r_rnw      <= 1'b0;
            r_wbyte    <= '0;
            r_prev_scl <= 1'b1;
            r_prev_sda <= 1'b1;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_bc       <= n_bc;
            r_wa       <= n_wa;
            r_dev      <= n_dev;
            r_rnw      <= n_rnw;
            r_wbyte    <= n_wbyte;
            r_prev_scl <= i_scl;
            r_prev_sda <= i_sda;
        end
    end

    // array addresses: write uses the present address, read the updated one
    assign cur_ab  = r_dev | {4'd0, r_wa};
    assign nxt_ab  = n_dev | {4'd0, n_wa};
    assign o_we    = i_step & wr_fire;
    assign o_waddr = cur_ab[MEM_ADDR_BITS-1:0];
    assign o_wdata = r_wbyte;
    assign o_raddr = nxt_ab[MEM_ADDR_BITS-1:0];

    always_comb begin
        o_info.phase     = n_phase;
        o_info.bit_count = n_bc;
        o_info.sda       = i_sda;
    end

endmodule

`default_nettype wire

FILE: sv/i2c_serial_eeprom_slave_core.sv
// top level of the serial eeprom slave: sequencer, byte array and output stage
//
// Each input beat is one sampled SCL/SDA pair and gives exactly one result beat
// carrying the SDA level driven back and the phase code. One beat is taken per
// clock while input is not stalled: the sequencer updates its state and writes
// the array in the accept cycle, and the byte at the updated address is read
// in the same cycle. The result passes the holding stage, then the output
// register. An output register plus one holding stage take one more input beat
// while a result waits; after that input is stalled. After reset the array is
// erased to 0xFF by a pass over all 2**MEM_ADDR_BITS addresses (65536 by
// default) during which input is stalled; configuration writes are taken as ever.
`default_nettype none

module i2c_serial_eeprom_slave_core #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [i2cee_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [i2cee_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_sda_in,
    input  wire logic                              i_scl_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_sda_out,
    output logic      [2:0]                        o_phase_code
);

    logic                      step;
    logic                      mem_we;
    logic [MEM_ADDR_BITS-1:0]  mem_waddr;
    logic [7:0]                mem_wdata;
    logic [MEM_ADDR_BITS-1:0]  mem_raddr;
    logic [7:0]                mem_rdata;
    logic                      mem_busy;
    i2cee_pkg::t_step_info     info;

    logic                      r_p_valid;
    i2cee_pkg::t_step_info     r_p_info;
    logic                      r_o_valid;
    logic                      r_o_sda;
    i2cee_pkg::t_phase         r_o_phase;

    logic                      o_take, o_free, p_move;
    logic [3:0]                sh;
    logic                      so;

    // handshake
    assign o_take     = r_o_valid & ~i_out_stall;
    assign o_free     = ~r_o_valid | o_take;
    assign p_move     = r_p_valid & o_free;
    assign o_in_stall = mem_busy | (r_p_valid & ~p_move);
    assign step       = i_in_valid & ~o_in_stall;

    i2cee_proto #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_proto (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_sda       (i_sda_in),
        .i_scl       (i_scl_in),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .o_info      (info)
    );

    i2cee_mem #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (step),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    // driven sda: data bit when reading, ack low in the ack slot of other phases, else echo
    assign sh = 4'd8 - r_p_info.bit_count;
    always_comb begin
        if (r_p_info.phase == i2cee_pkg::PH_READ) begin
            if (r_p_info.bit_count < i2cee_pkg::ACK_SLOT) begin
                so = (r_p_info.bit_count == 4'd0) ? 1'b0 : mem_rdata[sh[2:0]];
            end else begin
                so = r_p_info.sda;
            end
        end else if (r_p_info.bit_count == i2cee_pkg::ACK_SLOT) begin
            so = 1'b0;
        end else begin
            so = r_p_info.sda;
        end
    end

    // holding stage, waits for the array read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (step) begin
            r_p_valid <= 1'b1;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_p_info <= info;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_move) begin
            r_o_valid <= 1'b1;
        end else if (o_take) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_sda   <= so;
            r_o_phase <= r_p_info.phase;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_sda_out    = r_o_sda;
    assign o_phase_code = r_o_phase;

endmodule

`default_nettype wire

FILE: sv/i2cee_checker.sv
// port-level checks of the serial eeprom slave and their binding
`default_nettype none
`include "assert_macros.svh"

module i2cee_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_sda_out,
    input wire logic [2:0] o_phase_code
);

    // a held result beat keeps its payload
    `I2CEE_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sda_out) && $stable(o_phase_code)))

    // reset empties the output side
    `I2CEE_ASSERT_ALWAYS(a_rst_no_out, i_clk, !i_rst_n |=> !o_out_valid)

    // the erase pass holds off input right after reset
    `I2CEE_ASSERT_ALWAYS(a_rst_erase, i_clk, !i_rst_n |=> o_in_stall)

    // with the result held and one more beat taken, both stages are full
    `I2CEE_ASSERT(a_full_stall, i_clk, i_rst_n, (o_out_valid && i_out_stall && i_in_valid && !o_in_stall) |=> (!i_out_stall || o_in_stall))

endmodule

bind i2c_serial_eeprom_slave_core i2cee_checker u_i2cee_checker (.*);

`default_nettype wire

FILE: bench/tb_i2c_serial_eeprom_slave_core.sv
// self-checking bench for the serial eeprom slave core: pin sequences in, sda and phase out
`default_nettype none

module tb_i2c_serial_eeprom_slave_core;

    localparam int MEM_BITS        = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int PRINT_LIMIT     = 30;
    localparam int NUM_PHASES      = 7;

    // device type nibble sent ahead of the chip select bits
    localparam logic [3:0] DEV_TYPE = 4'b1010;

    // one-byte word address modes with different device shifts
    localparam logic [4:0] AMB_ONE_BYTE      = 5'd8;
    localparam logic [4:0] AMB_ONE_BYTE_WIDE = 5'd12;

    typedef struct packed {
        logic sda;
        logic scl;
        logic drain;
    } t_pin_beat;

    typedef struct {
        logic              sda;
        i2cee_pkg::t_phase phase;
        int unsigned       seq;
    } t_pin_reply;

    typedef struct {
        logic [4:0]  amb;
        logic [15:0] size;
        logic [7:0]  page;
        logic        gaps;
    } t_phase_plan;

    // dut ports
    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_cfg_we    = 1'b0;
    logic [i2cee_pkg::CFG_INDEX_W-1:0] i_cfg_index = i2cee_pkg::CFG_ADDR_MODE;
    logic [i2cee_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_stall;
    logic                              i_sda_in    = 1'b1;
    logic                              i_scl_in    = 1'b1;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic                              o_sda_out;
    logic [2:0]                        o_phase_code;

    // predicted register and protocol state
    logic [4:0]        mode_q;
    logic [15:0]       size_q;
    logic [7:0]        page_q;
    i2cee_pkg::t_phase ph_q;
    logic [3:0]        bit_q;
    logic [15:0]       word_q;
    logic [19:0]       dev_q;
    logic              rnw_q;
    logic [7:0]        wbyte_q;
    logic              prev_scl_q;
    logic              prev_sda_q;
    logic [7:0]        byte_store [0:(1<<MEM_BITS)-1];

    // stimulus and scoreboard
    t_pin_beat   pin_samples [$];
    t_pin_reply  replies_due [$];
    t_phase_plan plan [0:NUM_PHASES-1];
    logic        gen_sda     = 1'b1;
    logic        gen_scl     = 1'b1;
    logic        drain_req   = 1'b0;
    logic        idle_on     = 1'b0;
    logic        beat_taken  = 1'b0;
    int unsigned items_made  = 0;
    int unsigned beats_in    = 0;
    int unsigned err_count   = 0;
    int unsigned cycles      = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;

    i2c_serial_eeprom_slave_core #(
        .MEM_ADDR_BITS (MEM_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sda_in     (i_sda_in),
        .i_scl_in     (i_scl_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sda_out    (o_sda_out),
        .o_phase_code (o_phase_code)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (err_count < PRINT_LIMIT) begin
            $display("mismatch: %s", what);
        end
        err_count++;
    endtask

    // array address: device bits or'd over the word address, cut to the array width
    function automatic logic [MEM_BITS-1:0] array_index();
        logic [19:0] full;
        full = dev_q | {4'd0, word_q};
        return full[MEM_BITS-1:0];
    endfunction

    function automatic void begin_transfer();
        bit_q = '0;
        if (mode_q == i2cee_pkg::AMB_X24C01) begin
            word_q = '0;
            ph_q   = i2cee_pkg::PH_WORD7;
        end else begin
            dev_q = '0;
            ph_q  = i2cee_pkg::PH_DEVICE;
        end
    endfunction

    // advance the predicted slave by one pin sample and return the sda it drives
    task automatic eeprom_step(input logic sda, input logic scl, output logic sda_drv);
        logic        held, start_cond, stop_cond, fall, rise;
        int unsigned bc, pos, sh;
        logic [63:0] shifted;
        held       = prev_scl_q & scl;
        start_cond = held & prev_sda_q & ~sda;
        stop_cond  = held & ~prev_sda_q & sda;
        fall       = prev_scl_q & ~scl;
        rise       = ~prev_scl_q & scl;
        bc         = bit_q;

        if (ph_q == i2cee_pkg::PH_STANDBY) begin
            if (start_cond) begin_transfer();
        end else if (ph_q == i2cee_pkg::PH_WAIT_STOP) begin
            if (stop_cond) ph_q = i2cee_pkg::PH_STANDBY;
        end else if (start_cond) begin
            begin_transfer();
        end else if (stop_cond) begin
            ph_q = i2cee_pkg::PH_STANDBY;
        end else if (fall) begin
            // falling clock: count the bit, or close the byte after the ack clock
            if (bc < 9) begin
                bit_q = bit_q + 4'd1;
            end else begin
                bit_q = 4'd1;
                case (ph_q)
                    i2cee_pkg::PH_WORD7: begin
                        ph_q    = rnw_q ? i2cee_pkg::PH_READ : i2cee_pkg::PH_WRITE;
                        wbyte_q = '0;
                    end
                    i2cee_pkg::PH_DEVICE: begin
                        shifted = {44'd0, dev_q} << mode_q;
                        dev_q   = shifted[19:0];
                        if (rnw_q) begin
                            ph_q = i2cee_pkg::PH_READ;
                        end else begin
                            word_q = '0;
                            ph_q   = (mode_q == i2cee_pkg::AMB_TWO_BYTE) ?
                                     i2cee_pkg::PH_ADDR_HIGH : i2cee_pkg::PH_ADDR_LOW;
                        end
                    end
                    i2cee_pkg::PH_ADDR_HIGH: ph_q = i2cee_pkg::PH_ADDR_LOW;
                    i2cee_pkg::PH_ADDR_LOW: begin
                        ph_q    = i2cee_pkg::PH_WRITE;
                        wbyte_q = '0;
                    end
                    default: ;
                endcase
            end
        end else if (rise) begin
            // rising clock: latch the sampled bit for the current phase
            case (ph_q)
                i2cee_pkg::PH_WORD7: begin
                    if (bc < 8) begin
                        if (sda) word_q[7 - bc] = 1'b1;
                    end else if (bc == 8) begin
                        rnw_q = sda;
                    end
                end
                i2cee_pkg::PH_DEVICE: begin
                    if (bc > 4 && bc < 8) begin
                        if (sda) dev_q[7 - bc] = 1'b1;
                    end else if (bc == 8) begin
                        rnw_q = sda;
                    end
                end
                i2cee_pkg::PH_ADDR_HIGH, i2cee_pkg::PH_ADDR_LOW: begin
                    if (bc < 9) begin
                        pos = ((ph_q == i2cee_pkg::PH_ADDR_HIGH) ? 16 : 8) - bc;
                        if (pos <= 16 && {16'd0, size_q} < (32'd1 << pos)) begin
                            dev_q = dev_q >> 1;
                        end else if (sda && pos < 16) begin
                            word_q[pos] = 1'b1;
                        end
                    end
                end
                i2cee_pkg::PH_READ: begin
                    if (bc == 9) begin
                        if (sda) ph_q = i2cee_pkg::PH_WAIT_STOP;
                        else     word_q = (word_q + 16'd1) & size_q;
                    end
                end
                i2cee_pkg::PH_WRITE: begin
                    if (bc < 9) begin
                        if (sda && bc != 0) wbyte_q[8 - bc] = 1'b1;
                    end else begin
                        byte_store[array_index()] = wbyte_q;
                        wbyte_q = '0;
                        word_q  = (word_q & ~{8'd0, page_q}) |
                                  ((word_q + 16'd1) & {8'd0, page_q});
                    end
                end
                default: ;
            endcase
        end

        prev_scl_q = scl;
        prev_sda_q = sda;

        // driven level: read data bit, ack low in the ack slot outside reads, else the line itself
        if (ph_q == i2cee_pkg::PH_READ) begin
            if (bit_q < 9) begin
                sh      = 8 - bit_q;
                sda_drv = (sh < 8) ? byte_store[array_index()][sh] : 1'b0;
            end else begin
                sda_drv = sda;
            end
        end else if (bit_q == i2cee_pkg::ACK_SLOT) begin
            sda_drv = 1'b0;
        end else begin
            sda_drv = sda;
        end
    endtask

    // pin sequence builders
    task automatic push_pins(input logic sda, input logic scl);
        pin_samples.push_back('{sda, scl, drain_req});
        drain_req = 1'b0;
        gen_sda   = sda;
        gen_scl   = scl;
        items_made++;
    endtask

    task automatic send_bit(input logic b);
        push_pins(b, 1'b1);
        push_pins(b, 1'b0);
        if ($urandom_range(0, 9) == 0) push_pins(b, 1'b0);
    endtask

    task automatic send_byte(input logic [7:0] v, input logic ack);
        for (int i = 7; i >= 0; i--) send_bit(v[i]);
        send_bit(ack);
    endtask

    task automatic send_start();
        if (gen_scl) push_pins(gen_sda, 1'b0);
        push_pins(1'b1, 1'b0);
        push_pins(1'b1, 1'b1);
        push_pins(1'b0, 1'b1);
        push_pins(1'b0, 1'b0);
    endtask

    task automatic send_stop();
        if (gen_scl) push_pins(gen_sda, 1'b0);
        push_pins(1'b0, 1'b0);
        push_pins(1'b0, 1'b1);
        push_pins(1'b1, 1'b1);
    endtask

    // host acks every byte but the last, sometimes pokes the bus while waiting for stop
    task automatic read_bytes(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) send_byte(8'($urandom), k == n - 1);
        if ($urandom_range(0, 3) == 0) send_start();
        if ($urandom_range(0, 5) == 0) send_byte(8'($urandom), 1'b1);
        send_stop();
    endtask

    // one random bus transaction in the current address mode
    task automatic run_transfer();
        int unsigned pick, n;
        logic [15:0] word;
        logic [2:0]  chip;
        logic [6:0]  a7;
        pick = $urandom_range(0, 19);
        n    = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
        word = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
        chip = 3'($urandom);
        a7   = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 15));
        if ($urandom_range(0, 14) == 0) drain_req = 1'b1;

        if (pick < 2) begin
            // raw pin noise
            repeat ($urandom_range(3, 12)) push_pins(1'($urandom), 1'($urandom));
        end else if (pick < 5) begin
            // transfer cut short by stop or a fresh start
            send_start();
            repeat ($urandom_range(1, 12)) send_bit(1'($urandom));
            if ($urandom_range(0, 1) == 0) send_start();
            send_stop();
        end else if (mode_q == i2cee_pkg::AMB_X24C01) begin
            send_start();
            if (pick < 12) begin
                send_byte({a7, 1'b0}, 1'b1);
                for (int unsigned k = 0; k < n; k++) send_byte(8'($urandom), 1'b1);
                send_stop();
            end else begin
                send_byte({a7, 1'b1}, 1'b1);
                read_bytes(n);
            end
        end else begin
            send_start();
            if (pick < 15) begin
                send_byte({DEV_TYPE, chip, 1'b0}, 1'b1);
                if (mode_q == i2cee_pkg::AMB_TWO_BYTE) send_byte(word[15:8], 1'b1);
                send_byte(word[7:0], 1'b1);
                if (pick < 11) begin
                    for (int unsigned k = 0; k < n; k++) send_byte(8'($urandom), 1'b1);
                    send_stop();
                end else begin
                    // random read: repeated start into a read
                    send_start();
                    send_byte({DEV_TYPE, chip, 1'b1}, 1'b1);
                    read_bytes(n);
                end
            end else begin
                // current address read
                send_byte({DEV_TYPE, chip, 1'b1}, 1'b1);
                read_bytes(n);
            end
        end
    endtask

    task automatic write_reg(input logic [i2cee_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [i2cee_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            i2cee_pkg::CFG_ADDR_MODE: mode_q = data[4:0];
            i2cee_pkg::CFG_SIZE_MASK: size_q = data[15:0];
            i2cee_pkg::CFG_PAGE_MASK: page_q = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_regs(input t_phase_plan s);
        write_reg(i2cee_pkg::CFG_ADDR_MODE, 16'(s.amb));
        write_reg(i2cee_pkg::CFG_SIZE_MASK, s.size);
        write_reg(i2cee_pkg::CFG_PAGE_MASK, 16'(s.page));
        idle_on = s.gaps;
    endtask

    // hold until every queued beat has gone in and every result has come back
    task automatic wait_quiet();
        while (pin_samples.size() != 0 || replies_due.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // input driver: holds a stalled beat, inserts gap bursts, honours drain marks
    always @(negedge i_clk) begin : drive_pins
        logic      hold_valid;
        t_pin_beat beat;
        hold_valid = i_in_valid && !beat_taken;
        if (!hold_valid) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(0, 5);
                i_in_valid <= 1'b0;
            end else if (i_rst_n && pin_samples.size() != 0 &&
                         !(pin_samples[0].drain && replies_due.size() != 0)) begin
                beat = pin_samples.pop_front();
                i_sda_in   <= beat.sda;
                i_scl_in   <= beat.scl;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure in bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6);
        end
        i_out_stall <= (stall_left != 0);
    end

    // monitor: check result beats, then predict from accepted input beats
    always @(posedge i_clk) begin : watch_pins
        t_pin_reply want;
        logic       sda_drv;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result sda %b phase %0d",
                                              o_sda_out, o_phase_code));
                end else begin
                    want = replies_due.pop_front();
                    if (o_sda_out !== want.sda)
                        report_mismatch($sformatf("beat %0d sda_out got %b want %b",
                                                  want.seq, o_sda_out, want.sda));
                    if (o_phase_code !== want.phase)
                        report_mismatch($sformatf("beat %0d phase_code got %0d want %0d",
                                                  want.seq, o_phase_code, want.phase));
                end
            end
            beat_taken = i_in_valid && (o_in_stall === 1'b0);
            if (beat_taken) begin
                eeprom_step(i_sda_in, i_scl_in, sda_drv);
                replies_due.push_back('{sda_drv, ph_q, beats_in});
                beats_in++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, replies_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        plan[0] = '{i2cee_pkg::AMB_X24C01, i2cee_pkg::SIZE_MASK_RESET,
                    i2cee_pkg::PAGE_MASK_RESET, 1'b1};
        plan[1] = '{i2cee_pkg::AMB_TWO_BYTE, 16'hffff, 8'hff, 1'b1};
        plan[2] = '{AMB_ONE_BYTE,            16'h07ff, 8'h0f, 1'b0};
        plan[3] = '{i2cee_pkg::AMB_X24C01,   16'h0000, 8'h00, 1'b1};
        plan[4] = '{i2cee_pkg::AMB_TWO_BYTE, 16'h0fff, 8'h1f, 1'b1};
        plan[5] = '{AMB_ONE_BYTE_WIDE,       16'h00ff, 8'h07, 1'b1};
        plan[6] = '{AMB_ONE_BYTE,            16'h01ff, 8'h03, 1'b0};

        // predicted state after reset
        mode_q     = i2cee_pkg::AMB_RESET;
        size_q     = i2cee_pkg::SIZE_MASK_RESET;
        page_q     = i2cee_pkg::PAGE_MASK_RESET;
        ph_q       = i2cee_pkg::PH_STANDBY;
        bit_q      = '0;
        word_q     = '0;
        dev_q      = '0;
        rnw_q      = 1'b0;
        wbyte_q    = '0;
        prev_scl_q = 1'b1;
        prev_sda_q = 1'b1;
        foreach (byte_store[a]) byte_store[a] = 8'hff;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers go in while the array is being erased
        load_regs(plan[0]);

        // clock edges and a stop in standby are ignored
        push_pins(1'b1, 1'b0);
        push_pins(1'b0, 1'b0);
        push_pins(1'b0, 1'b1);
        push_pins(1'b1, 1'b1);
        // start, then two address bits
        push_pins(1'b0, 1'b1);
        push_pins(1'b0, 1'b0);
        push_pins(1'b1, 1'b1);
        push_pins(1'b1, 1'b0);
        push_pins(1'b0, 1'b1);
        push_pins(1'b0, 1'b0);
        // repeated start mid-byte restarts the bit count
        push_pins(1'b1, 1'b0);
        push_pins(1'b1, 1'b1);
        push_pins(1'b0, 1'b1);
        push_pins(1'b0, 1'b0);
        // stop ends the transfer
        push_pins(1'b0, 1'b1);
        push_pins(1'b1, 1'b1);

        // random traffic under each register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                wait_quiet();
                load_regs(plan[p]);
            end
            items_made = 0;
            while (items_made < ITEMS_PER_PHASE) begin
                if (p == 1 && items_made > 60 && items_made < 100) drain_req = 1'b1;
                run_transfer();
            end
            // sometimes leave a transfer open across the register change
            if (p != NUM_PHASES - 1 && $urandom_range(0, 1) == 0) begin
                send_start();
                repeat ($urandom_range(1, 10)) send_bit(1'($urandom));
            end
        end

        wait_quiet();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+sv
sv/i2cee_pkg.sv
sv/i2cee_mem.sv
sv/i2cee_proto.sv
sv/i2c_serial_eeprom_slave_core.sv
sv/i2cee_checker.sv
bench/tb_i2c_serial_eeprom_slave_core.sv
